// ===== rtl/sdt_pkg.sv =====
// shared types and constants of the signed decimal tokenizer
package sdt_pkg;

    localparam int CHAR_WIDTH   = 8;
    localparam int LIMIT_WIDTH  = 30;
    localparam int NUMBER_WIDTH = 31;
    localparam int KIND_WIDTH   = 2;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 30'd1000000000;

    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_NUMBER    = 2'd0,
        KIND_MALFORMED = 2'd1,
        KIND_SATURATED = 2'd2
    } kind_t;

    typedef struct packed {
        logic                           valid;
        kind_t                          kind;
        logic signed [NUMBER_WIDTH-1:0] number;
    } result_t;

endpackage

// ===== rtl/signed_decimal_tokenizer.sv =====
// signed decimal tokenizer top level: token state, limit register and result stage
//
// Input channel s_*: one text byte per word (s_char_code) with s_end_of_stream; a word
// with end of stream set finishes any pending number and clears the token state.
// Output channel m_*: one word per completed number (kind 0), malformed byte or
// token (kind 1) or saturated digit (kind 2); m_number is zero for events.
// Many input words produce no output word.
// cfg_wr_en / cfg_wr_data load the magnitude limit; write only while the block idles.
// A result is registered and appears on m_valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result register is not stalled; the token
// update and the times-ten add and limit compare are combinational ahead of the result register.
// Reset (aresetn low, synchronous) clears the token state and the output valid and
// loads the limit with 1000000000.
// When the receiver stalls with a result held, s_ready drops until it is taken; a
// held result does not block the next byte while m_ready is high.
module signed_decimal_tokenizer #(
    parameter int MAGNITUDE_WIDTH = 30
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [sdt_pkg::CHAR_WIDTH-1:0]          s_char_code,
    input  logic                                    s_end_of_stream,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [sdt_pkg::KIND_WIDTH-1:0]          m_kind,
    output logic signed [sdt_pkg::NUMBER_WIDTH-1:0] m_number,
    input  logic                                    cfg_wr_en,
    input  logic [sdt_pkg::LIMIT_WIDTH-1:0]         cfg_wr_data
);
    import sdt_pkg::*;

    logic [LIMIT_WIDTH-1:0]     limit_reg;
    logic                       in_token_reg;
    logic                       skipping_reg;
    logic                       negative_reg;
    logic [MAGNITUDE_WIDTH-1:0] magnitude_reg;
    logic                       in_token_next;
    logic                       skipping_next;
    logic                       negative_next;
    logic [MAGNITUDE_WIDTH-1:0] magnitude_next;
    result_t                    step_result;
    logic                       take_ok;
    logic                       accept;

    assign s_ready = take_ok;
    assign accept  = s_valid && take_ok;

    sdt_step #(
        .MAGNITUDE_WIDTH (MAGNITUDE_WIDTH)
    ) u_step (
        .char_code        (s_char_code),
        .end_of_stream    (s_end_of_stream),
        .magnitude_limit  (limit_reg),
        .in_token         (in_token_reg),
        .skipping         (skipping_reg),
        .is_negative      (negative_reg),
        .magnitude        (magnitude_reg),
        .in_token_next    (in_token_next),
        .skipping_next    (skipping_next),
        .is_negative_next (negative_next),
        .magnitude_next   (magnitude_next),
        .result           (step_result)
    );

    sdt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (step_result),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_kind   (m_kind),
        .m_number (m_number),
        .take_ok  (take_ok)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg  <= 1'b0;
            skipping_reg  <= 1'b0;
            negative_reg  <= 1'b0;
            magnitude_reg <= '0;
        end else if (accept) begin
            in_token_reg  <= in_token_next;
            skipping_reg  <= skipping_next;
            negative_reg  <= negative_next;
            magnitude_reg <= magnitude_next;
        end
    end

endmodule

// ===== rtl/sdt_step.sv =====
// next token state and result for one accepted word
module sdt_step #(
    parameter int MAGNITUDE_WIDTH = 30
) (
    input  logic [sdt_pkg::CHAR_WIDTH-1:0]  char_code,
    input  logic                            end_of_stream,
    input  logic [sdt_pkg::LIMIT_WIDTH-1:0] magnitude_limit,
    input  logic                            in_token,
    input  logic                            skipping,
    input  logic                            is_negative,
    input  logic [MAGNITUDE_WIDTH-1:0]      magnitude,
    output logic                            in_token_next,
    output logic                            skipping_next,
    output logic                            is_negative_next,
    output logic [MAGNITUDE_WIDTH-1:0]      magnitude_next,
    output sdt_pkg::result_t                result
);
    import sdt_pkg::*;

    // compute width covers limit and magnitude plus room for times ten
    localparam int CW = ((MAGNITUDE_WIDTH > LIMIT_WIDTH) ? MAGNITUDE_WIDTH : LIMIT_WIDTH) + 4;
    localparam int XW = (MAGNITUDE_WIDTH > NUMBER_WIDTH) ? MAGNITUDE_WIDTH : NUMBER_WIDTH;
    localparam logic [CW-1:0] MAG_MAX =
        {{(CW-MAGNITUDE_WIDTH){1'b0}}, {MAGNITUDE_WIDTH{1'b1}}};

    logic          is_digit;
    logic          is_minus;
    logic          is_space;
    logic [CW-1:0] limit_ext;
    logic [CW-1:0] limit_eff;
    logic [CW-1:0] mag_ext;
    logic [CW-1:0] mag_times_ten;
    logic [CW-1:0] mag_grown;
    logic [3:0]    digit_val;
    logic [XW-1:0] mag_x;
    logic [XW-1:0] signed_x;
    logic          tok_active;
    logic [CW-1:0] base_mag;

    always_comb begin
        is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_minus  = (char_code == CHAR_MINUS);
        is_space  = (char_code inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE});
        digit_val = 4'(char_code - CHAR_ZERO);

        limit_ext = CW'(magnitude_limit);
        limit_eff = (limit_ext < MAG_MAX) ? limit_ext : MAG_MAX;

        // a digit that opens a token starts from zero
        tok_active    = in_token;
        mag_ext       = CW'(magnitude);
        base_mag      = tok_active ? mag_ext : '0;
        mag_times_ten = (base_mag << 3) + (base_mag << 1);
        mag_grown     = mag_times_ten + CW'(digit_val);

        mag_x    = XW'(magnitude);
        signed_x = is_negative ? (XW'(0) - mag_x) : mag_x;

        in_token_next    = in_token;
        skipping_next    = skipping;
        is_negative_next = is_negative;
        magnitude_next   = magnitude;
        result.valid     = 1'b0;
        result.kind      = KIND_NUMBER;
        result.number    = '0;

        if (end_of_stream) begin
            if (!skipping && in_token) begin
                result.valid  = 1'b1;
                result.number = signed_x[NUMBER_WIDTH-1:0];
            end
            in_token_next    = 1'b0;
            skipping_next    = 1'b0;
            is_negative_next = 1'b0;
            magnitude_next   = '0;
        end else if (!is_digit && !is_minus && !is_space) begin
            in_token_next = 1'b0;
            skipping_next = 1'b1;
            result.valid  = 1'b1;
            result.kind   = KIND_MALFORMED;
        end else if (skipping) begin
            if (is_space) begin
                in_token_next = 1'b0;
                skipping_next = 1'b0;
            end
        end else if (is_minus) begin
            if (in_token) begin
                in_token_next = 1'b0;
                skipping_next = 1'b1;
                result.valid  = 1'b1;
                result.kind   = KIND_MALFORMED;
            end else begin
                magnitude_next   = '0;
                is_negative_next = 1'b1;
                in_token_next    = 1'b1;
            end
        end else if (is_digit) begin
            if (!in_token) begin
                is_negative_next = 1'b0;
                in_token_next    = 1'b1;
            end
            if (mag_grown > limit_eff) begin
                magnitude_next = limit_eff[MAGNITUDE_WIDTH-1:0];
                result.valid   = 1'b1;
                result.kind    = KIND_SATURATED;
            end else begin
                magnitude_next = mag_grown[MAGNITUDE_WIDTH-1:0];
            end
        end else if (in_token) begin
            // whitespace closes the token
            result.valid  = 1'b1;
            result.number = signed_x[NUMBER_WIDTH-1:0];
            in_token_next = 1'b0;
        end
    end

endmodule

// ===== rtl/sdt_out_stage.sv =====
// result register that holds a word until the receiver takes it
module sdt_out_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  sdt_pkg::result_t                     result,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [sdt_pkg::KIND_WIDTH-1:0]       m_kind,
    output logic signed [sdt_pkg::NUMBER_WIDTH-1:0] m_number,
    output logic                                 take_ok
);
    import sdt_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    kind_t                          kind_reg;
    logic signed [NUMBER_WIDTH-1:0] number_reg;

    // a new word may enter when the register is empty or drains this cycle
    assign take_ok = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take_ok) begin
            valid_next = load && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_ok && load && result.valid) begin
            kind_reg   <= result.kind;
            number_reg <= result.number;
        end
    end

    assign m_valid  = valid_reg;
    assign m_kind   = kind_reg;
    assign m_number = number_reg;

endmodule

// ===== rtl/sdt_checker.sv =====
// port-level checks of the signed decimal tokenizer, bound to the top level
module sdt_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic [sdt_pkg::CHAR_WIDTH-1:0]          s_char_code,
    input logic                                    s_end_of_stream,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic [sdt_pkg::KIND_WIDTH-1:0]          m_kind,
    input logic signed [sdt_pkg::NUMBER_WIDTH-1:0] m_number
);
    import sdt_pkg::*;

    logic bad_byte;

    assign bad_byte = !((s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE))
        && (s_char_code != CHAR_MINUS)
        && !((s_char_code >= CHAR_TAB) && (s_char_code <= CHAR_CR))
        && (s_char_code != CHAR_SPACE);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_number))
        else $error("result word changed while stalled");

    a_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_NUMBER) |-> (m_number == '0))
        else $error("event word carries a nonzero number");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result register full and stalled");

    a_malformed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_end_of_stream && bad_byte
        |=> m_valid && (m_kind == KIND_MALFORMED))
        else $error("invalid byte gave no malformed event");

endmodule

bind signed_decimal_tokenizer sdt_checker u_sdt_checker (.*);
